FILE: src/wait_for_graph_deadlock_detector_top_macros.svh
// Assertion macros for the wait-for graph deadlock detector.
`ifndef WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_TOP_MACROS_SVH
`define WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define WFGDD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wfgdd assertion failed");

// Condition must never be true outside reset.
`define WFGDD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("wfgdd forbidden condition seen");

`else

`define WFGDD_ASSERT(lbl, clk, rstn, prop)
`define WFGDD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: src/wfgdd_pkg.sv
// Package: sizes, datapath opcodes and controller/datapath interface types.
package wfgdd_pkg;

  localparam int MaxTx = 16;
  localparam int SlotW = $clog2(MaxTx);

  typedef logic [MaxTx-1:0] slot_mask_t;
  typedef logic [SlotW-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    DP_IDLE  = 2'd0,
    DP_LOAD  = 2'd1,
    DP_REACH = 2'd2,
    DP_PEEL  = 2'd3
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   res_we;
  } dp_cmd_t;

  typedef struct packed {
    logic pass_last;
    logic pass_changed;
    logic dead;
  } dp_status_t;

endpackage

FILE: src/wfgdd_dp.sv
// Datapath: wait-for row store, working slot set, sweep counter, result register.
module wfgdd_dp
  import wfgdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic        mode_i,
  input  slot_idx_t   tx_slot_i,
  input  logic [15:0] blocker_mask_i,
  output dp_status_t  status_o,
  output logic        deadlock_o
);

  slot_mask_t rows_q [MaxTx];
  slot_mask_t set_q, set_d;
  slot_idx_t  cnt_q, cnt_d;
  logic       chg_q, chg_d;
  logic       dead_q;

  slot_mask_t row_rd, grow, peel;
  logic       chg_now, last;

  assign row_rd = rows_q[cnt_q];
  assign last   = (cnt_q == slot_idx_t'(MaxTx - 1));

  // reach grows by the row of a member; peel drops a member with no edge into the set
  always_comb begin
    grow = set_q | (set_q[cnt_q] ? row_rd : '0);
    peel = set_q;
    if (set_q[cnt_q] && ((row_rd & set_q) == '0)) begin
      peel[cnt_q] = 1'b0;
    end
  end

  always_comb begin
    set_d = set_q;
    cnt_d = cnt_q;
    chg_d = chg_q;
    case (cmd_i.op)
      DP_LOAD: begin
        set_d = mode_i ? '0 : (slot_mask_t'(1) << tx_slot_i);
        cnt_d = '0;
        chg_d = 1'b0;
      end
      DP_REACH: set_d = grow;
      DP_PEEL:  set_d = peel;
      default:  set_d = set_q;
    endcase
    chg_now = (cmd_i.op == DP_REACH || cmd_i.op == DP_PEEL) && (set_d != set_q);
    if (cmd_i.op == DP_REACH || cmd_i.op == DP_PEEL) begin
      if (last) begin
        cnt_d = '0;
        chg_d = 1'b0;
      end else begin
        cnt_d = cnt_q + slot_idx_t'(1);
        chg_d = chg_q | chg_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q <= '0;
      cnt_q <= '0;
      chg_q <= 1'b0;
    end else begin
      set_q <= set_d;
      cnt_q <= cnt_d;
      chg_q <= chg_d;
    end
  end

  // row store, empty graph after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTx; i++) begin
        rows_q[i] <= '0;
      end
    end else if (cmd_i.op == DP_LOAD) begin
      rows_q[tx_slot_i] <= mode_i ? '0 : slot_mask_t'(blocker_mask_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      dead_q <= (set_q != '0);
    end
  end

  assign status_o.pass_last    = last;
  assign status_o.pass_changed = chg_q | chg_now;
  assign status_o.dead         = (set_q != '0);
  assign deadlock_o            = dead_q;

endmodule

FILE: src/wfgdd_ctrl.sv
// Controller: sequences load, reach sweeps, peel sweeps and result hand-off.
module wfgdd_ctrl
  import wfgdd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_REACH = 4'b0010,
    ST_PEEL  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = DP_IDLE;
    cmd_o.res_we  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          // clear item leaves an empty set, so the result is no deadlock
          state_d  = mode_i ? ST_DONE : ST_REACH;
        end
      end
      ST_REACH: begin
        cmd_o.op = DP_REACH;
        if (status_i.pass_last && !status_i.pass_changed) state_d = ST_PEEL;
      end
      ST_PEEL: begin
        cmd_o.op = DP_PEEL;
        if (status_i.pass_last && !status_i.pass_changed) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.res_we = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.res_we ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/wait_for_graph_deadlock_detector_top.sv
// Top level of the wait-for graph deadlock detector.
// Keeps one 16-bit blocker row per transaction slot (all empty after reset).
// A wait transfer (mode 0) replaces the row of tx_slot with blocker_mask and
// returns deadlock = 1 when a cycle, a self-edge included, is reachable from
// that slot; the row stays in place either way. A clear transfer (mode 1)
// empties the row and returns 0. One result transfer follows every input
// transfer, in order. Timing: the row store is read one row per cycle by a
// sweep counter. A wait item is loaded, then goes through 1 to 16 reach
// sweeps and then 1 to 17 peel sweeps over all 16 rows, the last sweep of
// each being the one that finds no change; then its result is loaded into
// the result register. A clear item is loaded and then goes straight to the
// result register. The result register sits between the two channels, so
// the next item is taken while a result still waits on out_stall_i.
`include "wait_for_graph_deadlock_detector_top_macros.svh"

module wait_for_graph_deadlock_detector_top
  import wfgdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [3:0]  tx_slot_i,
  input  logic [15:0] blocker_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        deadlock_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wfgdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  wfgdd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (mode_i),
    .tx_slot_i      (slot_idx_t'(tx_slot_i)),
    .blocker_mask_i (blocker_mask_i),
    .status_o       (status),
    .deadlock_o     (deadlock_o)
  );

  // block turns busy right after taking an item
  `WFGDD_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // result register is loaded only when the pending result is gone or leaving
  `WFGDD_ASSERT_NEVER(a_no_result_overwrite, clk_i, rst_ni,
                      cmd.res_we && out_valid_o && out_stall_i)

  // a clear item always yields an empty set, hence no deadlock
  `WFGDD_ASSERT(a_clear_no_dead, clk_i, rst_ni,
                (cmd.op == DP_LOAD && mode_i) |=> !status.dead)

endmodule
